// ----- hw/rtl/scrolled_tile_layer_fetch_assert.svh -----
// Assertion macros shared by the tile layer fetch RTL.
// Every macro is clocked and disabled while reset is asserted.
`ifndef SCROLLED_TILE_LAYER_FETCH_ASSERT_SVH
`define SCROLLED_TILE_LAYER_FETCH_ASSERT_SVH

// Property that must hold at every clock edge.
`define STLF_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define STLF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define STLF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/stlf_pkg.sv -----
// Package for the tile layer fetch block: codes, widths and shared types.
// No dependencies.
`default_nettype none

package stlf_pkg;

	localparam int APB_ADDR_W  = 5;
	localparam int DIV_BITS    = 16;
	localparam int MAP_ADDR_W  = 16;
	localparam int TS_IDX_W    = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [6:0] TILE_SIZE_MAX = 7'd64;

	// Input commands
	localparam logic [1:0] CMD_MAP_WR = 2'd0;
	localparam logic [1:0] CMD_TS_WR  = 2'd1;
	localparam logic [1:0] CMD_DRAW   = 2'd2;

	// Result status
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_DRAW = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;
	localparam logic [1:0] ST_ERR  = 2'd3;

	// Register indexes
	localparam logic [2:0] REG_TILE_SIZE     = 3'd0;
	localparam logic [2:0] REG_SCROLL_X      = 3'd1;
	localparam logic [2:0] REG_SCROLL_Y      = 3'd2;
	localparam logic [2:0] REG_MAP_WIDTH     = 3'd3;
	localparam logic [2:0] REG_MAP_HEIGHT    = 3'd4;
	localparam logic [2:0] REG_TILESET_COUNT = 3'd5;

	typedef enum logic [2:0] {
		OP_DONE,
		OP_MAP_WR,
		OP_TS_WR,
		OP_DRAW,
		OP_SKIP,
		OP_ERR
	} op_kind_t;

	// Classified transaction, front to back
	typedef struct packed {
		op_kind_t                kind;
		logic [MAP_ADDR_W-1:0]   addr;
		logic [15:0]             value;
		logic [7:0]              sheet_cols;
		logic [TS_IDX_W-1:0]     slot;
		logic signed [12:0]      dest_x;
		logic signed [12:0]      dest_y;
	} fetch_op_t;

	// Config seen by the front: clamped tile size, scroll split in tiles and pixels
	typedef struct packed {
		logic [6:0]  ts;
		logic [15:0] qx;
		logic [15:0] qy;
		logic [5:0]  rx;
		logic [5:0]  ry;
		logic [6:0]  map_width;
		logic [6:0]  map_height;
		logic [2:0]  tileset_count;
	} cfg_view_t;

	// One stage of the sheet row/column divider
	typedef struct packed {
		logic [1:0]            status;
		logic [TS_IDX_W-1:0]   pick;
		logic signed [12:0]    dest_x;
		logic signed [12:0]    dest_y;
		logic [DIV_BITS-1:0]   dvd;
		logic [7:0]            rem;
		logic [7:0]            sc;
	} div_t;

endpackage

`default_nettype wire

// ----- hw/rtl/stlf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stlf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/stlf_fifo.sv -----
// Short queue of classified transactions between front and back.
// Depends on stlf_pkg.
`default_nettype none

module stlf_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  stlf_pkg::fetch_op_t push_op,
	output logic                full,
	input  logic                pop,
	output stlf_pkg::fetch_op_t pop_op,
	output logic                empty
);
	import stlf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	fetch_op_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign pop_op = mem_q[rd_ptr_q];
	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign empty  = (cnt_q == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/stlf_front.sv -----
// Front end: classifies each input transaction and works out map address
// and screen position. Depends on stlf_pkg.
`default_nettype none

module stlf_front #(
	parameter int MAP_COLS     = 64,
	parameter int MAP_ROWS     = 64,
	parameter int NUM_TILESETS = 4
) (
	input  logic [1:0]          cmd,
	input  logic [5:0]          row,
	input  logic [5:0]          col,
	input  logic [15:0]         value,
	input  logic [7:0]          sheet_columns,
	input  logic [1:0]          tileset_slot,
	input  stlf_pkg::cfg_view_t cfg,
	output stlf_pkg::fetch_op_t op
);
	import stlf_pkg::*;

	logic [16:0]           tx;
	logic [16:0]           ty;
	logic                  in_map;
	logic                  wr_ok;
	logic                  slot_ok;
	logic [MAP_ADDR_W-1:0] draw_addr;
	logic [MAP_ADDR_W-1:0] wr_addr;
	logic [12:0]           px;
	logic [12:0]           py;

	// Slot plus whole-tile scroll gives the map cell
	assign tx = {1'b0, cfg.qx} + 17'(col);
	assign ty = {1'b0, cfg.qy} + 17'(row);

	assign in_map = (tx < 17'(cfg.map_width)) && (tx < 17'(MAP_COLS)) &&
			(ty < 17'(cfg.map_height)) && (ty < 17'(MAP_ROWS));

	assign draw_addr = MAP_ADDR_W'(ty[7:0]) * MAP_ADDR_W'(MAP_COLS) + MAP_ADDR_W'(tx[7:0]);
	assign wr_addr   = MAP_ADDR_W'(row) * MAP_ADDR_W'(MAP_COLS) + MAP_ADDR_W'(col);

	assign wr_ok   = ({3'd0, row} < 9'(MAP_ROWS)) && ({3'd0, col} < 9'(MAP_COLS));
	assign slot_ok = ({3'd0, tileset_slot} < 5'(NUM_TILESETS));

	assign px = 13'(col) * 13'(cfg.ts);
	assign py = 13'(row) * 13'(cfg.ts);

	always_comb begin
		op            = '0;
		op.addr       = (cmd == CMD_DRAW) ? draw_addr : wr_addr;
		op.value      = value;
		op.sheet_cols = sheet_columns;
		op.slot       = TS_IDX_W'(tileset_slot);
		op.dest_x     = $signed(px - 13'(cfg.rx));
		op.dest_y     = $signed(py - 13'(cfg.ry));
		case (cmd)
			CMD_MAP_WR: begin
				op.kind = wr_ok ? OP_MAP_WR : OP_DONE;
			end
			CMD_TS_WR: begin
				op.kind = slot_ok ? OP_TS_WR : OP_DONE;
			end
			CMD_DRAW: begin
				op.kind = in_map ? OP_DRAW : OP_SKIP;
			end
			default: begin
				op.kind = OP_ERR;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/stlf_cfg.sv -----
// APB register file plus a bit-serial divider that splits the scroll
// registers into whole tiles and pixel remainder. Depends on stlf_pkg.
`default_nettype none

`include "scrolled_tile_layer_fetch_assert.svh"

module stlf_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [stlf_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output stlf_pkg::cfg_view_t             cfg,
	output logic                            busy
);
	import stlf_pkg::*;

	localparam int STEP_W = $clog2(DIV_BITS);

	logic [2:0]        idx;
	logic              wr;
	logic              redo;
	logic [6:0]        tile_size_q;
	logic [15:0]       scroll_x_q;
	logic [15:0]       scroll_y_q;
	logic [6:0]        map_width_q;
	logic [6:0]        map_height_q;
	logic [2:0]        tileset_count_q;
	logic [6:0]        ts_eff;
	logic [15:0]       qx_q;
	logic [15:0]       qy_q;
	logic [5:0]        rx_q;
	logic [5:0]        ry_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [6:0]        sh_x;
	logic [6:0]        sh_y;
	logic              ge_x;
	logic              ge_y;
	logic [5:0]        rx_n;
	logic [5:0]        ry_n;

	assign idx  = paddr[APB_ADDR_W-1:2];
	assign wr   = psel && penable && pwrite;
	assign redo = wr && (idx == REG_TILE_SIZE || idx == REG_SCROLL_X || idx == REG_SCROLL_Y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_size_q     <= 7'd16;
			scroll_x_q      <= '0;
			scroll_y_q      <= '0;
			map_width_q     <= 7'd64;
			map_height_q    <= 7'd64;
			tileset_count_q <= '0;
		end else if (wr) begin
			case (idx)
				REG_TILE_SIZE:     tile_size_q     <= pwdata[6:0];
				REG_SCROLL_X:      scroll_x_q      <= pwdata[15:0];
				REG_SCROLL_Y:      scroll_y_q      <= pwdata[15:0];
				REG_MAP_WIDTH:     map_width_q     <= pwdata[6:0];
				REG_MAP_HEIGHT:    map_height_q    <= pwdata[6:0];
				REG_TILESET_COUNT: tileset_count_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TILE_SIZE:     prdata = 32'(tile_size_q);
			REG_SCROLL_X:      prdata = 32'(scroll_x_q);
			REG_SCROLL_Y:      prdata = 32'(scroll_y_q);
			REG_MAP_WIDTH:     prdata = 32'(map_width_q);
			REG_MAP_HEIGHT:    prdata = 32'(map_height_q);
			REG_TILESET_COUNT: prdata = 32'(tileset_count_q);
			default:           prdata = '0;
		endcase
	end

	// Zero reads as one, anything past the max as the max
	assign ts_eff = (tile_size_q == 7'd0) ? 7'd1 :
			((tile_size_q > TILE_SIZE_MAX) ? TILE_SIZE_MAX : tile_size_q);

	// Restoring division, one quotient bit per cycle; qx_q shifts dividend out
	// and quotient in
	assign sh_x = {rx_q, qx_q[DIV_BITS-1]};
	assign sh_y = {ry_q, qy_q[DIV_BITS-1]};
	assign ge_x = (sh_x >= ts_eff);
	assign ge_y = (sh_y >= ts_eff);
	assign rx_n = ge_x ? 6'(sh_x - ts_eff) : sh_x[5:0];
	assign ry_n = ge_y ? 6'(sh_y - ts_eff) : sh_y[5:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q   <= '0;
			qy_q   <= '0;
			rx_q   <= '0;
			ry_q   <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
		end else if (redo) begin
			qx_q   <= (idx == REG_SCROLL_X) ? pwdata[15:0] : scroll_x_q;
			qy_q   <= (idx == REG_SCROLL_Y) ? pwdata[15:0] : scroll_y_q;
			rx_q   <= '0;
			ry_q   <= '0;
			step_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			qx_q   <= {qx_q[DIV_BITS-2:0], ge_x};
			qy_q   <= {qy_q[DIV_BITS-2:0], ge_y};
			rx_q   <= rx_n;
			ry_q   <= ry_n;
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(DIV_BITS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;

	always_comb begin
		cfg               = '0;
		cfg.ts            = ts_eff;
		cfg.qx            = qx_q;
		cfg.qy            = qy_q;
		cfg.rx            = rx_q;
		cfg.ry            = ry_q;
		cfg.map_width     = map_width_q;
		cfg.map_height    = map_height_q;
		cfg.tileset_count = tileset_count_q;
	end

	`STLF_ASSERT(a_rem_below_tile, clk, arst_n, busy_q || (({1'b0, rx_q} < ts_eff) && ({1'b0, ry_q} < ts_eff)), "scroll remainder not below tile size")
	`STLF_ASSERT_NEXT(a_busy_on_redo, clk, arst_n, redo, busy_q, "divider did not start after scroll or tile size write")
	`STLF_ASSERT_NEXT(a_busy_ends, clk, arst_n, busy_q && !redo && step_q == STEP_W'(DIV_BITS - 1), !busy_q, "divider ran past its last step")

endmodule

`default_nettype wire

// ----- hw/rtl/stlf_back.sv -----
// Back end: map RAM access, tileset pick, pipelined sheet row/column divider
// and output register. Depends on stlf_pkg and stlf_ram.
`default_nettype none

`include "scrolled_tile_layer_fetch_assert.svh"

module stlf_back #(
	parameter int MAP_DEPTH    = 4096,
	parameter int NUM_TILESETS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          tileset_count,
	input  logic                op_empty,
	input  stlf_pkg::fetch_op_t op,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [1:0]          tileset_index,
	output logic signed [12:0]  dest_x,
	output logic signed [12:0]  dest_y,
	output logic [15:0]         src_row,
	output logic [7:0]          src_col
);
	import stlf_pkg::*;

	localparam int AW   = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int TS_W = (NUM_TILESETS > 1) ? $clog2(NUM_TILESETS) : 1;

	logic                adv;
	logic                ram_we;
	logic                ram_re;
	logic [15:0]         ram_rdata;
	logic [15:0]         first_q [NUM_TILESETS];
	logic [7:0]          sc_q [NUM_TILESETS];

	logic                v_s1;
	op_kind_t            kind_s1;
	logic signed [12:0]  dest_x_s1;
	logic signed [12:0]  dest_y_s1;

	logic [4:0]          cnt;
	logic [TS_W-1:0]     pick;
	logic [1:0]          status_n2;

	logic                v_s2;
	logic [1:0]          status_s2;
	logic [TS_W-1:0]     pick_s2;
	logic [15:0]         id_s2;
	logic [15:0]         first_s2;
	logic [7:0]          sc_s2;
	logic signed [12:0]  dest_x_s2;
	logic signed [12:0]  dest_y_s2;

	// div_s[0] is the third stage, div_s[k] holds k quotient bits
	logic [DIV_BITS:0]   div_v_s;
	div_t                div_s [DIV_BITS+1];
	div_t                div_n [DIV_BITS+1];

	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [1:0]          tileset_index_q;
	logic signed [12:0]  dest_x_q;
	logic signed [12:0]  dest_y_q;
	logic [15:0]         src_row_q;
	logic [7:0]          src_col_q;

	// Whole pipe moves together whenever the output slot is free or drained
	assign adv    = !out_valid_q || out_ready;
	assign pop    = adv && !op_empty;
	assign ram_we = pop && (op.kind == OP_MAP_WR);
	assign ram_re = pop && (op.kind == OP_DRAW);

	stlf_ram #(
		.WIDTH(16),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (op.addr[AW-1:0]),
		.wdata (op.value),
		.re    (ram_re),
		.raddr (op.addr[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Tileset table is written in transaction order, at dequeue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TILESETS; i++) begin
				first_q[i] <= '0;
				sc_q[i]    <= '0;
			end
		end else if (pop && op.kind == OP_TS_WR) begin
			first_q[op.slot[TS_W-1:0]] <= op.value;
			sc_q[op.slot[TS_W-1:0]]    <= op.sheet_cols;
		end
	end

	// Stage 2: tileset pick, lowest range that holds the id, else the last one
	always_comb begin
		cnt = (5'(tileset_count) > 5'(NUM_TILESETS)) ? 5'(NUM_TILESETS) : 5'(tileset_count);
		pick = TS_W'(cnt - 5'd1);
		for (int i = NUM_TILESETS - 2; i >= 0; i--) begin
			if ((i + 1) < int'(cnt) && ram_rdata >= first_q[i] && ram_rdata < first_q[i + 1]) begin
				pick = TS_W'(i);
			end
		end
		case (kind_s1)
			OP_DRAW: begin
				if (ram_rdata == 16'd0) begin
					status_n2 = ST_SKIP;
				end else if (cnt == 5'd0) begin
					status_n2 = ST_ERR;
				end else begin
					status_n2 = ST_DRAW;
				end
			end
			OP_SKIP: status_n2 = ST_SKIP;
			OP_ERR:  status_n2 = ST_ERR;
			default: status_n2 = ST_DONE;
		endcase
	end

	// Stage 3: range and sheet checks, offset into the sheet
	always_comb begin
		div_n[0]        = '0;
		div_n[0].status = (status_s2 == ST_DRAW && (id_s2 < first_s2 || sc_s2 == 8'd0)) ?
				ST_ERR : status_s2;
		div_n[0].pick   = TS_IDX_W'(pick_s2);
		div_n[0].dest_x = dest_x_s2;
		div_n[0].dest_y = dest_y_s2;
		div_n[0].dvd    = id_s2 - first_s2;
		div_n[0].rem    = '0;
		div_n[0].sc     = sc_s2;
	end

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		logic [8:0] sh;
		logic       ge;

		assign sh = {div_s[k].rem, div_s[k].dvd[DIV_BITS-1]};
		assign ge = (sh >= {1'b0, div_s[k].sc});

		always_comb begin
			div_n[k+1]     = div_s[k];
			div_n[k+1].rem = ge ? 8'(sh - {1'b0, div_s[k].sc}) : sh[7:0];
			div_n[k+1].dvd = {div_s[k].dvd[DIV_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			div_v_s     <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			div_v_s     <= {div_v_s[DIV_BITS-1:0], v_s2};
			out_valid_q <= div_v_s[DIV_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1   <= op.kind;
			dest_x_s1 <= op.dest_x;
			dest_y_s1 <= op.dest_y;

			status_s2 <= status_n2;
			pick_s2   <= pick;
			id_s2     <= ram_rdata;
			first_s2  <= first_q[pick];
			sc_s2     <= sc_q[pick];
			dest_x_s2 <= dest_x_s1;
			dest_y_s2 <= dest_y_s1;

			for (int k = 0; k <= DIV_BITS; k++) begin
				div_s[k] <= div_n[k];
			end

			status_q <= div_s[DIV_BITS].status;
			if (div_s[DIV_BITS].status == ST_DRAW) begin
				tileset_index_q <= div_s[DIV_BITS].pick[1:0];
				dest_x_q        <= div_s[DIV_BITS].dest_x;
				dest_y_q        <= div_s[DIV_BITS].dest_y;
				src_row_q       <= div_s[DIV_BITS].dvd;
				src_col_q       <= div_s[DIV_BITS].rem;
			end else begin
				tileset_index_q <= '0;
				dest_x_q        <= '0;
				dest_y_q        <= '0;
				src_row_q       <= '0;
				src_col_q       <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign tileset_index = tileset_index_q;
	assign dest_x        = dest_x_q;
	assign dest_y        = dest_y_q;
	assign src_row       = src_row_q;
	assign src_col       = src_col_q;

	`STLF_ASSERT_IMPL(a_div_rem, clk, arst_n, div_v_s[DIV_BITS] && div_s[DIV_BITS].status == ST_DRAW, div_s[DIV_BITS].rem < div_s[DIV_BITS].sc, "sheet column not below sheet columns")
	`STLF_ASSERT_NEXT(a_rdata_hold, clk, arst_n, !adv && v_s1, $stable(ram_rdata), "map read data changed during stall")
	`STLF_ASSERT_IMPL(a_idle_fields, clk, arst_n, out_valid_q && status_q != ST_DRAW, tileset_index_q == 2'd0 && dest_x_q == 13'sd0 && dest_y_q == 13'sd0 && src_row_q == 16'd0 && src_col_q == 8'd0, "non-draw result carries nonzero fields")

endmodule

`default_nettype wire

// ----- hw/rtl/scrolled_tile_layer_fetch.sv -----
// Tile layer fetch, top level; builds on stlf_pkg, stlf_cfg, stlf_front,
// stlf_fifo and stlf_back. The block takes one transaction per cycle whenever
// in_ready is high and gives one result per transaction, in order: the front
// classifies and computes the map address combinationally into a two-entry
// queue, the back reads the map RAM (one registered read port), picks the
// tileset, and runs the tile offset through a 16-stage divider for sheet row
// and column. The output is registered, so a stalled result holds the pipe but
// the queue keeps taking input until full. After any write to tile_size,
// scroll_x or scroll_y, in_ready is low while a bit-serial divider splits the
// scroll into whole tiles and pixel remainder. Map cells must be written
// before they are drawn; the map RAM is not cleared.
`default_nettype none

module scrolled_tile_layer_fetch #(
	parameter int MAP_COLS     = 64,
	parameter int MAP_ROWS     = 64,
	parameter int NUM_TILESETS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [stlf_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      cmd,
	input  logic [5:0]                      row,
	input  logic [5:0]                      col,
	input  logic [15:0]                     value,
	input  logic [7:0]                      sheet_columns,
	input  logic [1:0]                      tileset_slot,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic [1:0]                      tileset_index,
	output logic signed [12:0]              dest_x,
	output logic signed [12:0]              dest_y,
	output logic [15:0]                     src_row,
	output logic [7:0]                      src_col
);
	import stlf_pkg::*;

	localparam int MAP_DEPTH = MAP_ROWS * MAP_COLS;

	cfg_view_t cfg;
	logic      cfg_busy;
	fetch_op_t front_op;
	fetch_op_t queue_op;
	logic      q_full;
	logic      q_empty;
	logic      q_push;
	logic      q_pop;

	assign pready   = 1'b1;
	assign in_ready = !q_full && !cfg_busy;
	assign q_push   = in_valid && in_ready;

	stlf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg),
		.busy    (cfg_busy)
	);

	stlf_front #(
		.MAP_COLS     (MAP_COLS),
		.MAP_ROWS     (MAP_ROWS),
		.NUM_TILESETS (NUM_TILESETS)
	) u_front (
		.cmd           (cmd),
		.row           (row),
		.col           (col),
		.value         (value),
		.sheet_columns (sheet_columns),
		.tileset_slot  (tileset_slot),
		.cfg           (cfg),
		.op            (front_op)
	);

	stlf_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (front_op),
		.full    (q_full),
		.pop     (q_pop),
		.pop_op  (queue_op),
		.empty   (q_empty)
	);

	stlf_back #(
		.MAP_DEPTH    (MAP_DEPTH),
		.NUM_TILESETS (NUM_TILESETS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.tileset_count (cfg.tileset_count),
		.op_empty      (q_empty),
		.op            (queue_op),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.tileset_index (tileset_index),
		.dest_x        (dest_x),
		.dest_y        (dest_y),
		.src_row       (src_row),
		.src_col       (src_col)
	);

endmodule

`default_nettype wire
